/* rtl/core/escd_pkg.sv */
// Shared widths, calendar constants, tables and payload types of the serial date converter.
package escd_pkg;

  localparam int SERIAL_W = 22;
  localparam int YEAR_W   = 14;
  localparam int MONTH_W  = 4;
  localparam int DAY_W    = 5;
  localparam int WDAY_W   = 3;
  localparam int DNUM_W   = 22;  // days counted from 1600-03-01
  localparam int ERA_W    = 5;
  localparam int DOE_W    = 18;
  localparam int YOE_W    = 9;
  localparam int DOY_W    = 9;
  localparam int CENT_W   = 8;   // year / 100 over the full year field
  localparam int Q7_W     = 20;

  // Conversion direction
  localparam logic OP_DATE_TO_SERIAL = 1'b0;
  localparam logic OP_SERIAL_TO_DATE = 1'b1;

  localparam logic [YEAR_W-1:0]   YEAR_MIN   = 14'd1900;
  localparam logic [YEAR_W-1:0]   YEAR_MAX   = 14'd9999;
  localparam logic [YEAR_W-1:0]   EPOCH_YEAR = 14'd1600;
  localparam logic [SERIAL_W-1:0] SERIAL_MAX   = 22'd2958465;
  localparam logic [SERIAL_W-1:0] LOTUS_SERIAL = 22'd60;

  // Day numbers of 1900-03-01 and the serial offsets before and after the Lotus day
  localparam logic [DNUM_W-1:0] DNUM_MAR1900   = 22'd109572;
  localparam logic [DNUM_W-1:0] DNUM_OFS_EARLY = 22'd109512;
  localparam logic [DNUM_W-1:0] DNUM_OFS_LATE  = 22'd109511;

  localparam logic [DOE_W-1:0] ERA_DAYS  = 18'd146097;
  localparam logic [DOE_W-1:0] CENT1_DAY = 18'd36524;
  localparam logic [DOE_W-1:0] CENT2_DAY = 18'd73048;
  localparam logic [DOE_W-1:0] CENT3_DAY = 18'd109572;

  localparam logic [WDAY_W-1:0] WDAY_OFS   = 3'd3;
  localparam logic [WDAY_W-1:0] WDAY_LOTUS = 3'd4;
  localparam logic [DAY_W-1:0]  FEB_LEAP   = 5'd29;
  localparam logic [DAY_W-1:0]  FEB_PLAIN  = 5'd28;

  // Reciprocals for division by constants: q = (x * REC) >> SH, exact over the operand range
  localparam int REC100_SH  = 21;
  localparam int REC7_SH    = 25;
  localparam int RECERA_SH  = 40;
  localparam int REC1460_SH = 29;
  localparam int REC365_SH  = 27;
  localparam logic [14:0] REC100  = 15'(((64'd1 << REC100_SH) + 64'd99) / 64'd100);
  localparam logic [22:0] REC7    = 23'(((64'd1 << REC7_SH) + 64'd6) / 64'd7);
  localparam logic [22:0] RECERA  = 23'(((64'd1 << RECERA_SH) + 64'd146096) / 64'd146097);
  localparam logic [18:0] REC1460 = 19'(((64'd1 << REC1460_SH) + 64'd1459) / 64'd1460);
  localparam logic [18:0] REC365  = 19'(((64'd1 << REC365_SH) + 64'd364) / 64'd365);

  typedef struct packed {
    logic                opcode;
    logic [YEAR_W-1:0]   year;
    logic [MONTH_W-1:0]  month;
    logic [DAY_W-1:0]    day;
    logic [SERIAL_W-1:0] serial;
  } escd_cmd_t;

  typedef struct packed {
    logic [DNUM_W-1:0] dnum;
    logic              ok;
    logic              lotus;
  } escd_day_t;

  typedef struct packed {
    logic [ERA_W-1:0]    era;
    logic [DOE_W-1:0]    doe;
    logic [YOE_W-1:0]    yoe;
    logic [WDAY_W-1:0]   wday;
    logic [SERIAL_W-1:0] serial;
    logic                ok;
    logic                lotus;
  } escd_yoe_t;

  typedef struct packed {
    logic [SERIAL_W-1:0] serial_out;
    logic [YEAR_W-1:0]   year_out;
    logic [MONTH_W-1:0]  month_out;
    logic [DAY_W-1:0]    day_out;
    logic [WDAY_W-1:0]   weekday;
    logic [DAY_W-1:0]    month_length;
    logic                leap;
    logic                valid_res;
  } escd_res_t;

  // Days of each calendar month in a common year
  function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] m);
    logic [DAY_W-1:0] n;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: n = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    n = 5'd30;
      4'd2:                                       n = FEB_PLAIN;
      default:                                    n = 5'd0;
    endcase
    return n;
  endfunction

  // Days before month mp of a year that starts in March
  function automatic logic [DOY_W-1:0] cum_days(input logic [MONTH_W-1:0] mp);
    logic [DOY_W-1:0] n;
    case (mp)
      4'd0:    n = 9'd0;
      4'd1:    n = 9'd31;
      4'd2:    n = 9'd61;
      4'd3:    n = 9'd92;
      4'd4:    n = 9'd122;
      4'd5:    n = 9'd153;
      4'd6:    n = 9'd184;
      4'd7:    n = 9'd214;
      4'd8:    n = 9'd245;
      4'd9:    n = 9'd275;
      4'd10:   n = 9'd306;
      4'd11:   n = 9'd337;
      default: n = 9'd0;
    endcase
    return n;
  endfunction

  // Gregorian leap rule, given the year and its quotient by 100
  function automatic logic is_leap(input logic [YEAR_W-1:0] y, input logic [CENT_W-1:0] q);
    logic [YEAR_W-1:0] rem;
    rem = y - YEAR_W'(q) * 14'd100;
    return (rem == '0) ? (q[1:0] == 2'd0) : (y[1:0] == 2'd0);
  endfunction

  // Month length; February 1900 counts 29 days
  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m, input logic lp,
                                                 input logic y1900);
    logic [DAY_W-1:0] n;
    if (m == 4'd2) begin
      n = (lp || y1900) ? FEB_LEAP : FEB_PLAIN;
    end else begin
      n = month_days(m);
    end
    return n;
  endfunction

endpackage

/* rtl/core/escd_if.sv */
// Valid/ready channel interfaces for the converter's command and result streams.
interface escd_cmd_if;
  import escd_pkg::*;
  logic                valid;
  logic                ready;
  logic                opcode;
  logic [YEAR_W-1:0]   year;
  logic [MONTH_W-1:0]  month;
  logic [DAY_W-1:0]    day;
  logic [SERIAL_W-1:0] serial;

  modport source (output valid, output opcode, output year, output month, output day,
                  output serial, input ready);
  modport sink   (input valid, input opcode, input year, input month, input day,
                  input serial, output ready);
endinterface

interface escd_res_if;
  import escd_pkg::*;
  logic                valid;
  logic                ready;
  logic [SERIAL_W-1:0] serial_out;
  logic [YEAR_W-1:0]   year_out;
  logic [MONTH_W-1:0]  month_out;
  logic [DAY_W-1:0]    day_out;
  logic [WDAY_W-1:0]   weekday;
  logic [DAY_W-1:0]    month_length;
  logic                leap;
  logic                valid_res;

  modport source (output valid, output serial_out, output year_out, output month_out,
                  output day_out, output weekday, output month_length, output leap,
                  output valid_res, input ready);
  modport sink   (input valid, input serial_out, input year_out, input month_out,
                  input day_out, input weekday, input month_length, input leap,
                  input valid_res, output ready);
endinterface

/* rtl/core/escd_front.sv */
// Front stages: range checks and the day number from 1600-03-01 for either direction.
module escd_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  escd_pkg::escd_cmd_t in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output escd_pkg::escd_day_t out_data
);
  import escd_pkg::*;

  localparam int NSTG = 3;

  logic [NSTG-1:0] vld;
  logic [NSTG-1:0] adv;

  // Stage 1 registers
  logic                s1_op;
  logic [YEAR_W-1:0]   s1_year;
  logic [MONTH_W-1:0]  s1_month;
  logic [DAY_W-1:0]    s1_day;
  logic [YEAR_W-1:0]   s1_ybase;
  logic [CENT_W-1:0]   s1_ycent;
  logic [CENT_W-1:0]   s1_yq;
  logic [MONTH_W-1:0]  s1_mp;
  logic [DNUM_W-1:0]   s1_dser;
  logic                s1_sok;
  logic                s1_slotus;

  // Stage 2 registers
  logic                s2_op;
  logic [DNUM_W-1:0]   s2_tyear;
  logic [CENT_W-1:0]   s2_tcent;
  logic [9:0]          s2_tday;
  logic [DNUM_W-1:0]   s2_dser;
  logic                s2_ok;
  logic                s2_lotus;

  // Stage 3 registers
  escd_day_t           s3;

  logic [YEAR_W-1:0]   yy;
  logic [YEAR_W-1:0]   ybase;
  logic [28:0]         yb_prod;
  logic [28:0]         yr_prod;
  logic [SERIAL_W-1:0] sn;

  logic                leap_in;
  logic [DAY_W-1:0]    mlen_in;
  logic                d_ok;
  logic                d_lotus;

  // Ripple the stall back one stage at a time
  always_comb begin
    adv[NSTG-1] = !vld[NSTG-1] || out_ready;
    for (int k = NSTG - 2; k >= 0; k--) begin
      adv[k] = !vld[k] || adv[k+1];
    end
  end

  assign in_ready  = adv[0];
  assign out_valid = vld[NSTG-1];
  assign out_data  = s3;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[0]) begin
        vld[0] <= in_valid;
      end
      for (int k = 1; k < NSTG; k++) begin
        if (adv[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  // Shift the year to start in March and take the century quotients
  always_comb begin
    yy      = in_data.year - YEAR_W'(in_data.month <= 4'd2);
    ybase   = yy - EPOCH_YEAR;
    yb_prod = 29'(ybase) * 29'(REC100);
    yr_prod = 29'(in_data.year) * 29'(REC100);
    sn      = (in_data.serial > LOTUS_SERIAL) ? in_data.serial - 22'd1 : in_data.serial;
  end

  always_ff @(posedge clk) begin
    if (adv[0] && in_valid) begin
      s1_op     <= in_data.opcode;
      s1_year   <= in_data.year;
      s1_month  <= in_data.month;
      s1_day    <= in_data.day;
      s1_ybase  <= ybase;
      s1_ycent  <= yb_prod[REC100_SH +: CENT_W];
      s1_yq     <= yr_prod[REC100_SH +: CENT_W];
      s1_mp     <= (in_data.month > 4'd2) ? in_data.month - 4'd3 : in_data.month + 4'd9;
      s1_dser   <= sn + DNUM_OFS_EARLY;
      s1_sok    <= (in_data.serial != '0) && (in_data.serial <= SERIAL_MAX);
      s1_slotus <= (in_data.serial == LOTUS_SERIAL);
    end
  end

  // Check the year and month ranges and the day against its month length
  always_comb begin
    leap_in = is_leap(s1_year, s1_yq);
    mlen_in = month_len(s1_month, leap_in, s1_year == YEAR_MIN);
    d_ok    = (s1_year >= YEAR_MIN) && (s1_year <= YEAR_MAX) &&
              (s1_month >= 4'd1) && (s1_month <= 4'd12) &&
              (s1_day >= 5'd1) && (s1_day <= mlen_in);
    d_lotus = (s1_year == YEAR_MIN) && (s1_month == 4'd2) && (s1_day == FEB_LEAP);
  end

  always_ff @(posedge clk) begin
    if (adv[1] && vld[0]) begin
      s2_op    <= s1_op;
      s2_tyear <= DNUM_W'(s1_ybase) * 22'd365 + DNUM_W'(s1_ybase >> 2);
      s2_tcent <= s1_ycent - (s1_ycent >> 2);
      s2_tday  <= 10'(cum_days(s1_mp)) + 10'(s1_day) - 10'd1;
      s2_dser  <= s1_dser;
      s2_ok    <= (s1_op == OP_SERIAL_TO_DATE) ? s1_sok : d_ok;
      s2_lotus <= (s1_op == OP_SERIAL_TO_DATE) ? s1_slotus : d_lotus;
    end
  end

  // Pick the day number of the chosen direction
  always_ff @(posedge clk) begin
    if (adv[2] && vld[1]) begin
      s3.dnum  <= (s2_op == OP_SERIAL_TO_DATE) ? s2_dser
                  : s2_tyear - DNUM_W'(s2_tcent) + DNUM_W'(s2_tday);
      s3.ok    <= s2_ok;
      s3.lotus <= s2_lotus;
    end
  end

endmodule

/* rtl/core/escd_split.sv */
// Middle stages: era, day of era, year of era, weekday and serial from the day number.
module escd_split (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  escd_pkg::escd_day_t in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output escd_pkg::escd_yoe_t out_data
);
  import escd_pkg::*;

  localparam int NSTG = 5;

  logic [NSTG-1:0] vld;
  logic [NSTG-1:0] adv;

  // Stage 1
  logic [DNUM_W-1:0]   s1_dnum;
  logic [ERA_W-1:0]    s1_era;
  logic [Q7_W-1:0]     s1_q7;
  logic                s1_ok;
  logic                s1_lotus;

  // Stage 2 to 5 carry the partial result
  escd_yoe_t           s2;
  escd_yoe_t           s3;
  logic [6:0]          s3_a;
  logic [1:0]          s3_bc;
  escd_yoe_t           s4;
  logic [DOE_W-1:0]    s4_t;
  escd_yoe_t           s5;

  logic [44:0]         era_prod;
  logic [44:0]         q7_prod;
  logic [DOE_W-1:0]    doe;
  logic [WDAY_W-1:0]   r7;
  logic [WDAY_W:0]     wsum;
  logic [36:0]         a_prod;
  logic [36:0]         y_prod;

  always_comb begin
    adv[NSTG-1] = !vld[NSTG-1] || out_ready;
    for (int k = NSTG - 2; k >= 0; k--) begin
      adv[k] = !vld[k] || adv[k+1];
    end
  end

  assign in_ready  = adv[0];
  assign out_valid = vld[NSTG-1];
  assign out_data  = s5;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[0]) begin
        vld[0] <= in_valid;
      end
      for (int k = 1; k < NSTG; k++) begin
        if (adv[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  // Divide the day number by the era length and by seven
  assign era_prod = 45'(in_data.dnum) * 45'(RECERA);
  assign q7_prod  = 45'(in_data.dnum) * 45'(REC7);

  always_ff @(posedge clk) begin
    if (adv[0] && in_valid) begin
      s1_dnum  <= in_data.dnum;
      s1_era   <= era_prod[RECERA_SH +: ERA_W];
      s1_q7    <= q7_prod[REC7_SH +: Q7_W];
      s1_ok    <= in_data.ok;
      s1_lotus <= in_data.lotus;
    end
  end

  // Take the remainders; 1600-03-01 was a Wednesday
  always_comb begin
    doe  = DOE_W'(s1_dnum - DNUM_W'(s1_era) * DNUM_W'(ERA_DAYS));
    r7   = WDAY_W'(s1_dnum - DNUM_W'(s1_q7) * 22'd7);
    wsum = {1'b0, r7} + {1'b0, WDAY_OFS};
  end

  always_ff @(posedge clk) begin
    if (adv[1] && vld[0]) begin
      s2.era    <= s1_era;
      s2.doe    <= doe;
      s2.yoe    <= '0;
      s2.wday   <= (wsum >= 4'd7) ? WDAY_W'(wsum - 4'd7) : WDAY_W'(wsum);
      s2.serial <= (s1_dnum < DNUM_MAR1900) ? s1_dnum - DNUM_OFS_EARLY
                                            : s1_dnum - DNUM_OFS_LATE;
      s2.ok     <= s1_ok;
      s2.lotus  <= s1_lotus;
    end
  end

  // Count leap days inside the era: four-year and century terms
  assign a_prod = 37'(s2.doe) * 37'(REC1460);

  always_ff @(posedge clk) begin
    if (adv[2] && vld[1]) begin
      s3    <= s2;
      s3_a  <= a_prod[REC1460_SH +: 7];
      s3_bc <= 2'(s2.doe >= CENT1_DAY) + 2'(s2.doe >= CENT2_DAY) + 2'(s2.doe >= CENT3_DAY);
    end
  end

  always_ff @(posedge clk) begin
    if (adv[3] && vld[2]) begin
      s4   <= s3;
      s4_t <= s3.doe - DOE_W'(s3_a) + DOE_W'(s3_bc);
    end
  end

  // Year of era from the leap-corrected day count
  assign y_prod = 37'(s4_t) * 37'(REC365);

  always_ff @(posedge clk) begin
    if (adv[4] && vld[3]) begin
      s5.era    <= s4.era;
      s5.doe    <= s4.doe;
      s5.yoe    <= y_prod[REC365_SH +: YOE_W];
      s5.wday   <= s4.wday;
      s5.serial <= s4.serial;
      s5.ok     <= s4.ok;
      s5.lotus  <= s4.lotus;
    end
  end

endmodule

/* rtl/core/escd_finish.sv */
// Back stages: month and day, calendar year, leap flag, month length and the result register.
module escd_finish (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  escd_pkg::escd_yoe_t in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output escd_pkg::escd_res_t out_data
);
  import escd_pkg::*;

  localparam int NSTG = 5;

  logic [NSTG-1:0] vld;
  logic [NSTG-1:0] adv;

  typedef struct packed {
    logic [ERA_W-1:0]    era;
    logic [YOE_W-1:0]    yoe;
    logic [DOY_W-1:0]    doy;
    logic [WDAY_W-1:0]   wday;
    logic [SERIAL_W-1:0] serial;
    logic                ok;
    logic                lotus;
  } doy_stage_t;

  typedef struct packed {
    logic [YEAR_W-1:0]   year;
    logic [MONTH_W-1:0]  month;
    logic [DAY_W-1:0]    day;
    logic [WDAY_W-1:0]   wday;
    logic [SERIAL_W-1:0] serial;
    logic                ok;
    logic                lotus;
  } date_stage_t;

  doy_stage_t          s1;
  doy_stage_t          s2;
  logic [MONTH_W-1:0]  s2_mp;
  date_stage_t         s3;
  date_stage_t         s4;
  logic [CENT_W-1:0]   s4_q;
  escd_res_t           s5;

  logic [1:0]          ycent;
  logic [DOE_W-1:0]    ydays;
  logic [MONTH_W-1:0]  mp_cnt;
  logic [MONTH_W-1:0]  month;
  logic [28:0]         q_prod;
  logic                lp;

  always_comb begin
    adv[NSTG-1] = !vld[NSTG-1] || out_ready;
    for (int k = NSTG - 2; k >= 0; k--) begin
      adv[k] = !vld[k] || adv[k+1];
    end
  end

  assign in_ready  = adv[0];
  assign out_valid = vld[NSTG-1];
  assign out_data  = s5;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[0]) begin
        vld[0] <= in_valid;
      end
      for (int k = 1; k < NSTG; k++) begin
        if (adv[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  // Day of the March-based year
  always_comb begin
    ycent = 2'(in_data.yoe >= 9'd100) + 2'(in_data.yoe >= 9'd200) + 2'(in_data.yoe >= 9'd300);
    ydays = DOE_W'(in_data.yoe) * 18'd365 + DOE_W'(in_data.yoe >> 2) - DOE_W'(ycent);
  end

  always_ff @(posedge clk) begin
    if (adv[0] && in_valid) begin
      s1.era    <= in_data.era;
      s1.yoe    <= in_data.yoe;
      s1.doy    <= DOY_W'(in_data.doe - ydays);
      s1.wday   <= in_data.wday;
      s1.serial <= in_data.serial;
      s1.ok     <= in_data.ok;
      s1.lotus  <= in_data.lotus;
    end
  end

  // Find the month by counting the month starts already passed
  always_comb begin
    mp_cnt = '0;
    for (int i = 1; i < 12; i++) begin
      mp_cnt = mp_cnt + MONTH_W'(s1.doy >= cum_days(MONTH_W'(i)));
    end
  end

  always_ff @(posedge clk) begin
    if (adv[1] && vld[0]) begin
      s2    <= s1;
      s2_mp <= mp_cnt;
    end
  end

  // Rebuild the calendar date
  assign month = (s2_mp < 4'd10) ? s2_mp + 4'd3 : s2_mp - 4'd9;

  always_ff @(posedge clk) begin
    if (adv[2] && vld[1]) begin
      s3.year   <= YEAR_W'(s2.yoe) + YEAR_W'(s2.era) * 14'd400 +
                   YEAR_W'(month <= 4'd2) + EPOCH_YEAR;
      s3.month  <= month;
      s3.day    <= DAY_W'(s2.doy - cum_days(s2_mp) + 9'd1);
      s3.wday   <= s2.wday;
      s3.serial <= s2.serial;
      s3.ok     <= s2.ok;
      s3.lotus  <= s2.lotus;
    end
  end

  assign q_prod = 29'(s3.year) * 29'(REC100);

  always_ff @(posedge clk) begin
    if (adv[3] && vld[2]) begin
      s4   <= s3;
      s4_q <= q_prod[REC100_SH +: CENT_W];
    end
  end

  assign lp = is_leap(s4.year, s4_q);

  // Zero a rejected item, substitute the Lotus day, else deliver the decoded date
  always_ff @(posedge clk) begin
    if (adv[4] && vld[3]) begin
      if (!s4.ok) begin
        s5 <= '0;
      end else if (s4.lotus) begin
        s5.serial_out   <= LOTUS_SERIAL;
        s5.year_out     <= YEAR_MIN;
        s5.month_out    <= 4'd2;
        s5.day_out      <= FEB_LEAP;
        s5.weekday      <= WDAY_LOTUS;
        s5.month_length <= FEB_LEAP;
        s5.leap         <= 1'b0;
        s5.valid_res    <= 1'b1;
      end else begin
        s5.serial_out   <= s4.serial;
        s5.year_out     <= s4.year;
        s5.month_out    <= s4.month;
        s5.day_out      <= s4.day;
        s5.weekday      <= s4.wday;
        s5.month_length <= month_len(s4.month, lp, s4.year == YEAR_MIN);
        s5.leap         <= lp;
        s5.valid_res    <= 1'b1;
      end
    end
  end

endmodule

/* rtl/core/excel_serial_date_converter_unit.sv */
// Top level of the 1900-system serial date converter.
// Converts a Gregorian date to its 1900-system spreadsheet serial (opcode 0) or a serial back
// to a date (opcode 1), counting the fictitious 1900-02-29 as serial 60, and returns serial,
// date, weekday (0 is Sunday), month length, leap flag and a valid flag; a rejected input
// returns valid_res 0 with every other field zero. The block keeps no state and accepts one
// transfer per clock unless the result channel stalls; each command passes through the front,
// split and finish stages, whose registers spread out the constant-reciprocal multiplies
// (century, era, weekday, leap-day and year quotients). Every stage has its own valid bit
// and a stalled result only holds back stages that are full, so empty stages keep filling.
module excel_serial_date_converter_unit (
  input logic        clk,
  input logic        rst,
  escd_cmd_if.sink   cmd,
  escd_res_if.source res
);
  import escd_pkg::*;

  escd_cmd_t cmd_data;
  escd_day_t day_data;
  escd_yoe_t yoe_data;
  escd_res_t res_data;
  logic      day_valid;
  logic      day_ready;
  logic      yoe_valid;
  logic      yoe_ready;

  // Gather the command fields
  always_comb begin
    cmd_data.opcode = cmd.opcode;
    cmd_data.year   = cmd.year;
    cmd_data.month  = cmd.month;
    cmd_data.day    = cmd.day;
    cmd_data.serial = cmd.serial;
  end

  escd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (cmd.valid),
    .in_ready  (cmd.ready),
    .in_data   (cmd_data),
    .out_valid (day_valid),
    .out_ready (day_ready),
    .out_data  (day_data)
  );

  escd_split u_split (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (day_valid),
    .in_ready  (day_ready),
    .in_data   (day_data),
    .out_valid (yoe_valid),
    .out_ready (yoe_ready),
    .out_data  (yoe_data)
  );

  escd_finish u_finish (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (yoe_valid),
    .in_ready  (yoe_ready),
    .in_data   (yoe_data),
    .out_valid (res.valid),
    .out_ready (res.ready),
    .out_data  (res_data)
  );

  // Spread the result onto the channel
  always_comb begin
    res.serial_out   = res_data.serial_out;
    res.year_out     = res_data.year_out;
    res.month_out    = res_data.month_out;
    res.day_out      = res_data.day_out;
    res.weekday      = res_data.weekday;
    res.month_length = res_data.month_length;
    res.leap         = res_data.leap;
    res.valid_res    = res_data.valid_res;
  end

endmodule

/* rtl/core/escd_checker.sv */
// Port-level checks on the converter's result channel, bound to the top level.
module escd_checker (
  input logic        clk,
  input logic        rst,
  input logic        res_valid,
  input logic        res_ready,
  input logic [21:0] serial_out,
  input logic [13:0] year_out,
  input logic [3:0]  month_out,
  input logic [4:0]  day_out,
  input logic [2:0]  weekday,
  input logic [4:0]  month_length,
  input logic        leap,
  input logic        valid_res
);

  // Hold a stalled result
  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(serial_out) && $stable(year_out) &&
                                $stable(valid_res))
    else $error("stalled result changed");

  // Drop every result after reset
  a_reset: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid right after reset");

  // Clear all fields of a rejected item
  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && !valid_res |-> serial_out == 22'd0 && year_out == 14'd0 &&
      month_out == 4'd0 && day_out == 5'd0 && weekday == 3'd0 && month_length == 5'd0 &&
      !leap)
    else $error("rejected item carries nonzero fields");

  // Keep an accepted date self-consistent
  a_date_sane: assert property (@(posedge clk) disable iff (rst)
    res_valid && valid_res |-> month_out >= 4'd1 && month_out <= 4'd12 && day_out >= 5'd1 &&
      day_out <= month_length && weekday <= 3'd6 && serial_out >= 22'd1 &&
      year_out >= 14'd1900)
    else $error("accepted date out of range");

  // Map serial 60 to the Lotus day only
  a_lotus: assert property (@(posedge clk) disable iff (rst)
    res_valid && valid_res && serial_out == 22'd60 |-> year_out == 14'd1900 &&
      month_out == 4'd2 && day_out == 5'd29 && !leap && weekday == 3'd4)
    else $error("serial 60 not decoded as 1900-02-29");

endmodule

bind excel_serial_date_converter_unit escd_checker u_escd_checker (
  .clk          (clk),
  .rst          (rst),
  .res_valid    (res.valid),
  .res_ready    (res.ready),
  .serial_out   (res.serial_out),
  .year_out     (res.year_out),
  .month_out    (res.month_out),
  .day_out      (res.day_out),
  .weekday      (res.weekday),
  .month_length (res.month_length),
  .leap         (res.leap),
  .valid_res    (res.valid_res)
);

/* bench/excel_serial_date_converter_unit_tb.sv */
// Self-checking bench for the serial date converter: directed table, random commands, scoreboard.
`timescale 1ns / 100ps

module excel_serial_date_converter_unit_tb;
  import escd_pkg::*;

  localparam int RANDOM_ITEMS = 1500;
  localparam int HOLD_CYCLES  = 300;
  localparam int IDLE_PCT     = 18;
  localparam int DRAIN_CYCLES = 40;
  localparam int MAX_REPORTS  = 10;

  // One row of the directed table: a command and, where given, its result typed by hand
  typedef struct {
    escd_cmd_t cmd;
    bit        typed;
    escd_res_t want;
  } table_row_t;

  logic clk = 1'b0;
  logic rst;

  escd_cmd_if cmd_ch ();
  escd_res_if res_ch ();

  excel_serial_date_converter_unit i_dut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_ch),
    .res (res_ch)
  );

  table_row_t directed_q[$];
  escd_res_t  conv_result_q[$];

  // Expectation riding along with the command on the channel
  bit        row_typed;
  escd_res_t row_want;

  // Flow control shared with the receiver
  bit calm;
  bit stall_rx_req;
  bit hold_done;
  int hold_left;

  int err_count;
  int checked_count;
  int date_cmd_count;
  int serial_cmd_count;
  int rejected_count;

  escd_res_t got_res;
  escd_res_t want_res;
  escd_cmd_t seen_cmd;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // ---------------------------------------------------------------- calendar predictor

  function automatic bit greg_leap(input int unsigned y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  // February 1900 gets the fictitious 29th
  function automatic int unsigned month_span(input int unsigned y, input int unsigned m);
    int unsigned len;
    case (m)
      1, 3, 5, 7, 8, 10, 12: len = 31;
      4, 6, 9, 11:           len = 30;
      2:                     len = (greg_leap(y) || y == 1900) ? 29 : 28;
      default:               len = 0;
    endcase
    return len;
  endfunction

  // Zeller's congruence, rotated so that Sunday is 0
  function automatic int unsigned zeller_weekday(input int unsigned y, input int unsigned m,
                                                 input int unsigned d);
    int unsigned yy, mm, k, j, h;
    yy = y;
    mm = m;
    if (mm < 3) begin
      mm = mm + 12;
      yy = yy - 1;
    end
    k = yy % 100;
    j = yy / 100;
    h = (d + (13 * (mm + 1)) / 5 + k + k / 4 + j / 4 + 5 * j) % 7;
    return (h + 6) % 7;
  endfunction

  // Day count from 0000-03-01, proleptic Gregorian
  function automatic int unsigned day_count(input int unsigned y, input int unsigned m,
                                            input int unsigned d);
    int unsigned yy, era, yoe, mp, doy, doe;
    yy  = (m <= 2) ? y - 1 : y;
    era = yy / 400;
    yoe = yy - era * 400;
    mp  = (m > 2) ? m - 3 : m + 9;
    doy = (153 * mp + 2) / 5 + d - 1;
    doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
    return era * 146097 + doe;
  endfunction

  function automatic void date_of_count(input int unsigned n, output int unsigned y,
                                        output int unsigned m, output int unsigned d);
    int unsigned era, doe, yoe, doy, mp;
    era = n / 146097;
    doe = n - era * 146097;
    yoe = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
    doy = doe - (365 * yoe + yoe / 4 - yoe / 100);
    mp  = (5 * doy + 2) / 153;
    d   = doy - (153 * mp + 2) / 5 + 1;
    m   = (mp < 10) ? mp + 3 : mp - 9;
    y   = yoe + era * 400 + ((m <= 2) ? 1 : 0);
  endfunction

  function automatic escd_res_t predict_conversion(input escd_cmd_t c);
    escd_res_t   r;
    int unsigned y, m, d, s, base;
    r    = '0;
    base = day_count(1900, 1, 1);
    if (c.opcode == OP_DATE_TO_SERIAL) begin
      y = c.year;
      m = c.month;
      d = c.day;
      if (y < YEAR_MIN || y > YEAR_MAX || m < 1 || m > 12) return r;
      if (d < 1 || d > month_span(y, m)) return r;
      if (y == 1900 && m == 2 && d == 29) begin
        s = LOTUS_SERIAL;
      end else begin
        // real dates from March 1900 on sit one past the plain day count
        s = day_count(y, m, d) - base + 1 + ((y > 1900 || m >= 3) ? 1 : 0);
      end
    end else begin
      s = c.serial;
      if (s < 1 || s > SERIAL_MAX) return r;
      if (s == LOTUS_SERIAL) begin
        y = 1900;
        m = 2;
        d = 29;
      end else begin
        date_of_count(base + ((s > LOTUS_SERIAL) ? s - 1 : s) - 1, y, m, d);
      end
    end
    r.serial_out   = SERIAL_W'(s);
    r.year_out     = YEAR_W'(y);
    r.month_out    = MONTH_W'(m);
    r.day_out      = DAY_W'(d);
    r.weekday      = WDAY_W'(zeller_weekday(y, m, d));
    r.month_length = DAY_W'(month_span(y, m));
    r.leap         = greg_leap(y);
    r.valid_res    = 1'b1;
    return r;
  endfunction

  // ---------------------------------------------------------------- stimulus

  task automatic add_row(input escd_cmd_t c, input bit t, input escd_res_t w);
    table_row_t row;
    row.cmd   = c;
    row.typed = t;
    row.want  = w;
    directed_q.insert(directed_q.size(), row);
  endtask

  function automatic int unsigned pick_year();
    int unsigned sel;
    sel = $urandom_range(9, 0);
    if (sel < 4) return 1900 + $urandom_range(5, 0);
    if (sel < 6) return 100 * $urandom_range(99, 19) + $urandom_range(1, 0);
    if (sel < 7) return 9999 - $urandom_range(3, 0);
    return $urandom_range(9999, 1900);
  endfunction

  function automatic escd_cmd_t random_command();
    escd_cmd_t   c;
    int unsigned pick, y, m, len, sel;
    // unused fields stay random so that every bit moves
    c.opcode = 1'($urandom_range(1, 0));
    c.year   = YEAR_W'($urandom_range(16383, 0));
    c.month  = MONTH_W'($urandom_range(15, 0));
    c.day    = DAY_W'($urandom_range(31, 0));
    c.serial = SERIAL_W'($urandom_range(4194303, 0));
    pick = $urandom_range(99, 0);
    if (pick < 45) begin
      y   = pick_year();
      m   = $urandom_range(12, 1);
      len = month_span(y, m);
      c.opcode = OP_DATE_TO_SERIAL;
      c.year   = YEAR_W'(y);
      c.month  = MONTH_W'(m);
      c.day    = DAY_W'(($urandom_range(3, 0) == 0) ? len : $urandom_range(len, 1));
    end else if (pick < 82) begin
      sel = $urandom_range(9, 0);
      c.opcode = OP_SERIAL_TO_DATE;
      if (sel < 3) c.serial = SERIAL_W'($urandom_range(200, 1));
      else if (sel < 4) c.serial = SERIAL_MAX - SERIAL_W'($urandom_range(50, 0));
      else c.serial = SERIAL_W'($urandom_range(SERIAL_MAX, 1));
    end else if (pick < 92) begin
      // dates just past a limit
      y   = pick_year();
      m   = $urandom_range(12, 1);
      sel = $urandom_range(3, 0);
      c.opcode = OP_DATE_TO_SERIAL;
      c.year   = YEAR_W'(y);
      c.month  = MONTH_W'(m);
      c.day    = DAY_W'(month_span(y, m) + 1);
      if (sel == 1) c.year = ($urandom_range(1, 0) == 0) ? YEAR_MIN - 1 : YEAR_MAX + 1;
      if (sel == 2) c.month = ($urandom_range(1, 0) == 0) ? 4'd0 : 4'd13;
      if (sel == 3) c.day = 5'd0;
    end
    return c;
  endfunction

  // Offer one command, idling first at random, and hold it until the transfer
  task automatic send_cmd(input escd_cmd_t c, input bit t, input escd_res_t w);
    while (!calm && $urandom_range(99, 0) < IDLE_PCT) begin
      cmd_ch.valid <= 1'b0;
      @(posedge clk);
    end
    cmd_ch.valid  <= 1'b1;
    cmd_ch.opcode <= c.opcode;
    cmd_ch.year   <= c.year;
    cmd_ch.month  <= c.month;
    cmd_ch.day    <= c.day;
    cmd_ch.serial <= c.serial;
    row_typed     <= t;
    row_want      <= w;
    @(posedge clk);
    while (!cmd_ch.ready) @(posedge clk);
  endtask

  // ---------------------------------------------------------------- receiver

  initial begin
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst) begin
        res_ch.ready <= 1'b0;
      end else if (hold_left != 0) begin
        res_ch.ready <= 1'b0;
        hold_left = hold_left - 1;
      end else if (stall_rx_req && !hold_done) begin
        // long hold-off so the pipeline backs up into the command channel
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= calm || ($urandom_range(99, 0) >= IDLE_PCT);
      end
    end
  end

  // ---------------------------------------------------------------- scoreboard

  always @(posedge clk) begin
    if (!rst) begin
      // check a result transfer against the oldest expectation
      if (res_ch.valid && res_ch.ready) begin
        got_res = '{res_ch.serial_out, res_ch.year_out, res_ch.month_out, res_ch.day_out,
                    res_ch.weekday, res_ch.month_length, res_ch.leap, res_ch.valid_res};
        if (conv_result_q.size() == 0) begin
          err_count = err_count + 1;
          if (err_count <= MAX_REPORTS)
            $display("unexpected result: serial %0d date %0d-%0d-%0d valid %0b",
                     got_res.serial_out, got_res.year_out, got_res.month_out,
                     got_res.day_out, got_res.valid_res);
        end else begin
          want_res = conv_result_q.pop_front();
          checked_count = checked_count + 1;
          if (!want_res.valid_res) rejected_count = rejected_count + 1;
          if (got_res !== want_res) begin
            err_count = err_count + 1;
            if (err_count <= MAX_REPORTS)
              $display({"result %0d mismatch (exp/act): serial %0d/%0d year %0d/%0d ",
                        "month %0d/%0d day %0d/%0d wday %0d/%0d len %0d/%0d leap %0b/%0b ",
                        "valid %0b/%0b"}, checked_count,
                       want_res.serial_out, got_res.serial_out,
                       want_res.year_out, got_res.year_out,
                       want_res.month_out, got_res.month_out,
                       want_res.day_out, got_res.day_out,
                       want_res.weekday, got_res.weekday,
                       want_res.month_length, got_res.month_length,
                       want_res.leap, got_res.leap,
                       want_res.valid_res, got_res.valid_res);
          end
        end
      end
      // record the expectation of a command transfer
      if (cmd_ch.valid && cmd_ch.ready) begin
        seen_cmd = '{cmd_ch.opcode, cmd_ch.year, cmd_ch.month, cmd_ch.day, cmd_ch.serial};
        if (seen_cmd.opcode == OP_SERIAL_TO_DATE) serial_cmd_count = serial_cmd_count + 1;
        else date_cmd_count = date_cmd_count + 1;
        conv_result_q.insert(conv_result_q.size(),
                             row_typed ? row_want : predict_conversion(seen_cmd));
      end
    end
  end

  // ---------------------------------------------------------------- main sequence

  initial begin
    rst          <= 1'b1;
    cmd_ch.valid <= 1'b0;
    cmd_ch.opcode <= OP_DATE_TO_SERIAL;
    cmd_ch.year   <= '0;
    cmd_ch.month  <= '0;
    cmd_ch.day    <= '0;
    cmd_ch.serial <= '0;
    row_typed     <= 1'b0;
    row_want      <= '0;

    // serial to date: first day, Lotus day, its neighbors, last day, out of range
    add_row('{OP_SERIAL_TO_DATE, 14'd0, 4'd0, 5'd0, 22'd1}, 1'b1,
            '{22'd1, 14'd1900, 4'd1, 5'd1, 3'd1, 5'd31, 1'b0, 1'b1});
    add_row('{OP_SERIAL_TO_DATE, 14'd0, 4'd0, 5'd0, 22'd60}, 1'b1,
            '{22'd60, 14'd1900, 4'd2, 5'd29, 3'd4, 5'd29, 1'b0, 1'b1});
    add_row('{OP_SERIAL_TO_DATE, 14'd0, 4'd0, 5'd0, 22'd59}, 1'b0, '0);
    add_row('{OP_SERIAL_TO_DATE, 14'd0, 4'd0, 5'd0, 22'd61}, 1'b0, '0);
    add_row('{OP_SERIAL_TO_DATE, 14'd0, 4'd0, 5'd0, 22'd2958465}, 1'b1,
            '{22'd2958465, 14'd9999, 4'd12, 5'd31, 3'd5, 5'd31, 1'b0, 1'b1});
    add_row('{OP_SERIAL_TO_DATE, 14'd0, 4'd0, 5'd0, 22'd0}, 1'b1, '0);
    add_row('{OP_SERIAL_TO_DATE, 14'd0, 4'd0, 5'd0, 22'd2958466}, 1'b1, '0);
    add_row('{OP_SERIAL_TO_DATE, 14'h3FFF, 4'hF, 5'h1F, 22'h3FFFFF}, 1'b1, '0);
    // date to serial: first day, Lotus day, its neighbors, last day
    add_row('{OP_DATE_TO_SERIAL, 14'd1900, 4'd1, 5'd1, 22'h3FFFFF}, 1'b1,
            '{22'd1, 14'd1900, 4'd1, 5'd1, 3'd1, 5'd31, 1'b0, 1'b1});
    add_row('{OP_DATE_TO_SERIAL, 14'd1900, 4'd2, 5'd29, 22'd0}, 1'b1,
            '{22'd60, 14'd1900, 4'd2, 5'd29, 3'd4, 5'd29, 1'b0, 1'b1});
    add_row('{OP_DATE_TO_SERIAL, 14'd1900, 4'd2, 5'd28, 22'd0}, 1'b0, '0);
    add_row('{OP_DATE_TO_SERIAL, 14'd1900, 4'd3, 5'd1, 22'd0}, 1'b0, '0);
    add_row('{OP_DATE_TO_SERIAL, 14'd9999, 4'd12, 5'd31, 22'd0}, 1'b1,
            '{22'd2958465, 14'd9999, 4'd12, 5'd31, 3'd5, 5'd31, 1'b0, 1'b1});
    // impossible dates
    add_row('{OP_DATE_TO_SERIAL, 14'd1899, 4'd12, 5'd31, 22'd0}, 1'b1, '0);
    add_row('{OP_DATE_TO_SERIAL, 14'd10000, 4'd1, 5'd1, 22'd0}, 1'b1, '0);
    add_row('{OP_DATE_TO_SERIAL, 14'h3FFF, 4'hF, 5'h1F, 22'd0}, 1'b1, '0);
    add_row('{OP_DATE_TO_SERIAL, 14'd2000, 4'd0, 5'd10, 22'd0}, 1'b1, '0);
    add_row('{OP_DATE_TO_SERIAL, 14'd2000, 4'd13, 5'd1, 22'd0}, 1'b1, '0);
    add_row('{OP_DATE_TO_SERIAL, 14'd2000, 4'd1, 5'd0, 22'd0}, 1'b1, '0);
    add_row('{OP_DATE_TO_SERIAL, 14'd2023, 4'd4, 5'd31, 22'd0}, 1'b1, '0);
    add_row('{OP_DATE_TO_SERIAL, 14'd1900, 4'd2, 5'd30, 22'd0}, 1'b1, '0);
    add_row('{OP_DATE_TO_SERIAL, 14'd2100, 4'd2, 5'd29, 22'd0}, 1'b1, '0);
    // leap days that exist, and the last day of a common year
    add_row('{OP_DATE_TO_SERIAL, 14'd2000, 4'd2, 5'd29, 22'd0}, 1'b0, '0);
    add_row('{OP_DATE_TO_SERIAL, 14'd2024, 4'd2, 5'd29, 22'd0}, 1'b0, '0);
    add_row('{OP_DATE_TO_SERIAL, 14'd2023, 4'd12, 5'd31, 22'd0}, 1'b0, '0);

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < directed_q.size(); i++)
      send_cmd(directed_q[i].cmd, directed_q[i].typed, directed_q[i].want);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == 300) stall_rx_req = 1'b1;
      if (i == 700) begin
        // drain everything before going on
        cmd_ch.valid <= 1'b0;
        @(posedge clk);
        while (conv_result_q.size() != 0) @(posedge clk);
      end
      calm = (i >= 1000 && i < 1250);
      send_cmd(random_command(), 1'b0, '0);
    end
    calm = 1'b0;

    // wait out the pipeline
    cmd_ch.valid <= 1'b0;
    @(posedge clk);
    while (conv_result_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("ran %0d date-to-serial and %0d serial-to-date commands, %0d of them rejected",
             date_cmd_count, serial_cmd_count, rejected_count);
    $display("%0d results checked with %0d failures, including a long receiver hold-off",
             checked_count, err_count);
    if (err_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #1_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
